// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at each rising edge outside reset.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/dbq_pkg.sv =====
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared constants and types for the bounded deque with search.
// ----------------------------------------------------------------------------
package dbq_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_CONTAINS   = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic               en;
    logic [PTR_W-1:0]   addr;
    logic [VALUE_W-1:0] data;
  } wr_req_t;

endpackage

// ===== src/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed values in a ring store, with a
// sequential front-to-back search.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  request: action, operand_value
// m_*       out  m_tvalid/m_tready  result: popped value, found, status,
//                                   count, empty, front, back
//
// A push, pop or no-op request passes through the exec, front, back and
// last steps after the idle step accepts it. A contains query on a
// non-empty queue adds a scan step that compares up to 16 entries one at a
// time, set by the single read port of the store feeding one comparator.
// s_tready is high only while the sequencer is idle; the result register
// lets the next request in while a result is still held on m_*. The last
// step waits while a held result has not been taken.
// rst clears pointers, count and control; store contents stay undefined.
//
`include "assert_macros.svh"

module bounded_deque_with_search (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] action, [34:3] operand_value, [39:35] zero
  input  logic [39:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] popped_value, [32] found, [34:33] status, [39:35] entry_count,
  // [40] is_empty, [72:41] front_value, [104:73] back_value, [111:105] zero
  output logic [111:0] m_tdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_BACK  = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;

  logic [2:0]                        state;
  logic [2:0]                        act;
  logic [dbq_pkg::VALUE_W-1:0]       opnd;
  logic [dbq_pkg::PTR_W-1:0]         front;
  logic [dbq_pkg::CNT_W-1:0]         count;
  logic [dbq_pkg::CNT_W-1:0]         scan_idx;
  logic [dbq_pkg::CNT_W-1:0]         scan_next;
  logic [dbq_pkg::VALUE_W-1:0]       popped;
  logic                              found;
  logic [1:0]                        status;
  logic                              is_pop;
  logic [dbq_pkg::VALUE_W-1:0]       front_val;
  logic [dbq_pkg::PTR_W-1:0]         back_addr;
  logic                              full;
  logic                              empty;
  logic                              hit;
  logic                              out_free;
  dbq_pkg::wr_req_t                  wr;
  logic                              rd_en;
  logic [dbq_pkg::PTR_W-1:0]         rd_addr;
  logic [dbq_pkg::VALUE_W-1:0]       rd_data;

  assign s_tready  = (state == S_IDLE);
  assign back_addr = front + count[dbq_pkg::PTR_W-1:0] - dbq_pkg::PTR_W'(1);
  assign full      = (count == dbq_pkg::CNT_W'(dbq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign scan_next = scan_idx + dbq_pkg::CNT_W'(1);
  assign hit       = (rd_data == opnd);
  assign out_free  = !m_tvalid || m_tready;

  // store write on pushes
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = front + count[dbq_pkg::PTR_W-1:0];
    wr.data = opnd;
    if (state == S_EXEC && !full) begin
      if (act == dbq_pkg::ACT_PUSH_FRONT) begin
        wr.en   = 1'b1;
        wr.addr = front - dbq_pkg::PTR_W'(1);
      end else if (act == dbq_pkg::ACT_PUSH_BACK) begin
        wr.en = 1'b1;
      end
    end
  end

  // single read port address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = back_addr;
    unique case (state)
      S_EXEC: begin
        rd_en   = 1'b1;
        rd_addr = (act == dbq_pkg::ACT_POP_BACK) ? back_addr : front;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = front + scan_next[dbq_pkg::PTR_W-1:0];
      end
      S_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = front;
      end
      S_BACK: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  dbq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      count    <= '0;
      scan_idx <= '0;
      is_pop   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_LAST && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act    <= s_tdata[2:0];
            opnd   <= s_tdata[34:3];
            popped <= '0;
            found  <= 1'b0;
            status <= dbq_pkg::STATUS_OK;
            is_pop <= 1'b0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state    <= (act == dbq_pkg::ACT_CONTAINS && !empty) ? S_SCAN : S_FRONT;
          scan_idx <= '0;
          case (act)
            dbq_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                status <= dbq_pkg::STATUS_FULL;
              end else begin
                front <= front - dbq_pkg::PTR_W'(1);
                count <= count + dbq_pkg::CNT_W'(1);
              end
            end
            dbq_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                status <= dbq_pkg::STATUS_FULL;
              end else begin
                count <= count + dbq_pkg::CNT_W'(1);
              end
            end
            dbq_pkg::ACT_POP_FRONT: begin
              if (empty) begin
                status <= dbq_pkg::STATUS_EMPTY;
              end else begin
                is_pop <= 1'b1;
                front  <= front + dbq_pkg::PTR_W'(1);
                count  <= count - dbq_pkg::CNT_W'(1);
              end
            end
            dbq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                status <= dbq_pkg::STATUS_EMPTY;
              end else begin
                is_pop <= 1'b1;
                count  <= count - dbq_pkg::CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            state <= S_FRONT;
          end else if (scan_next == count) begin
            state <= S_FRONT;
          end else begin
            scan_idx <= scan_next;
          end
        end
        S_FRONT: begin
          if (is_pop) begin
            popped <= rd_data;
          end
          state <= S_BACK;
        end
        S_BACK: begin
          front_val <= rd_data;
          state     <= S_LAST;
        end
        S_LAST: begin
          if (out_free) begin
            m_tdata  <= {7'd0,
                         empty ? '0 : rd_data,
                         empty ? '0 : front_val,
                         empty, count, status, found, popped};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_count_bound, 1'b1, count <= dbq_pkg::CNT_W'(dbq_pkg::DEPTH))
  `ASSERT_IMPL(a_scan_in_range, state == S_SCAN, scan_idx < count)
  `ASSERT_NEXT(a_count_only_exec, state != S_EXEC, $stable(count) && $stable(front))
  `ASSERT_IMPL(a_result_from_last, $rose(m_tvalid), $past(state) == S_LAST)

endmodule

// ===== src/dbq_store.sv =====
// ----------------------------------------------------------------------------
// dbq_store
// Ring entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dbq_store (
  input  logic                         clk,
  input  dbq_pkg::wr_req_t             wr,
  input  logic                         rd_en,
  input  logic [dbq_pkg::PTR_W-1:0]    rd_addr,
  output logic [dbq_pkg::VALUE_W-1:0]  rd_data
);

  logic [dbq_pkg::VALUE_W-1:0] mem [dbq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== verif/tb_bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search
// Self-checking bench for the bounded deque: a shadow ring store predicts
// every result, and the bench checks each one field by field. Directed
// requests cover the empty, extreme and no-op cases. Fill, drain and mixed
// bursts of random requests drive the queue to full and empty in four
// phases of source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 260;
  localparam int TAIL_CYCLES    = 40;

  // {operand_value, action}, matching s_tdata[34:0]
  typedef struct packed {
    logic [dbq_pkg::VALUE_W-1:0] operand;
    logic [2:0]                  action;
  } deque_req_t;

  // matches m_tdata[104:0], lowest field last
  typedef struct packed {
    logic [dbq_pkg::VALUE_W-1:0] back_value;
    logic [dbq_pkg::VALUE_W-1:0] front_value;
    logic                        is_empty;
    logic [dbq_pkg::CNT_W-1:0]   entry_count;
    logic [1:0]                  status;
    logic                        found;
    logic [dbq_pkg::VALUE_W-1:0] popped_value;
  } deque_rsp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;

  bounded_deque_with_search i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  deque_req_t                  pending_requests[$];
  deque_rsp_t                  expected_results[$];
  logic [dbq_pkg::VALUE_W-1:0] recent_pushes[$];

  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // shadow of the ring store
  logic [dbq_pkg::VALUE_W-1:0] shadow_store[dbq_pkg::DEPTH];
  logic [dbq_pkg::PTR_W-1:0]   shadow_front = '0;
  int                          shadow_count = 0;

  int n_requests = 0, n_pushes = 0, n_pops = 0, n_full = 0, n_empty = 0;
  int n_searches = 0, n_hits = 0, n_noops = 0;

  function automatic deque_rsp_t deque_apply(deque_req_t r);
    deque_rsp_t res;
    logic [dbq_pkg::PTR_W-1:0] slot;
    res = '0;
    n_requests++;
    case (r.action) inside
      dbq_pkg::ACT_PUSH_FRONT, dbq_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= dbq_pkg::DEPTH) begin
          res.status = dbq_pkg::STATUS_FULL;
          n_full++;
        end else begin
          if (r.action == dbq_pkg::ACT_PUSH_FRONT) begin
            shadow_front = shadow_front - dbq_pkg::PTR_W'(1);
            slot = shadow_front;
          end else begin
            slot = shadow_front + dbq_pkg::PTR_W'(shadow_count);
          end
          shadow_store[slot] = r.operand;
          shadow_count++;
          n_pushes++;
        end
      end
      dbq_pkg::ACT_POP_FRONT, dbq_pkg::ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = dbq_pkg::STATUS_EMPTY;
          n_empty++;
        end else begin
          if (r.action == dbq_pkg::ACT_POP_FRONT) begin
            res.popped_value = shadow_store[shadow_front];
            shadow_front = shadow_front + dbq_pkg::PTR_W'(1);
          end else begin
            res.popped_value =
              shadow_store[shadow_front + dbq_pkg::PTR_W'(shadow_count - 1)];
          end
          shadow_count--;
          n_pops++;
        end
      end
      dbq_pkg::ACT_CONTAINS: begin
        n_searches++;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_store[shadow_front + dbq_pkg::PTR_W'(i)] == r.operand)
            res.found = 1'b1;
        end
        if (res.found) n_hits++;
      end
      default: n_noops++;
    endcase
    res.entry_count = dbq_pkg::CNT_W'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    if (shadow_count != 0) begin
      res.front_value = shadow_store[shadow_front];
      res.back_value  = shadow_store[shadow_front + dbq_pkg::PTR_W'(shadow_count - 1)];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [dbq_pkg::VALUE_W-1:0] got,
                             logic [dbq_pkg::VALUE_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= {5'b0, pending_requests.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // request capture, result check, watchdog
  always @(posedge clk) begin
    deque_rsp_t got;
    deque_rsp_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_results.push_back(deque_apply(deque_req_t'(s_tdata[34:0])));
      if (m_tvalid && m_tready) begin
        got = deque_rsp_t'(m_tdata[104:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", got.popped_value, want.popped_value);
          check_field("found", dbq_pkg::VALUE_W'(got.found),
                      dbq_pkg::VALUE_W'(want.found));
          check_field("status", dbq_pkg::VALUE_W'(got.status),
                      dbq_pkg::VALUE_W'(want.status));
          check_field("entry_count", dbq_pkg::VALUE_W'(got.entry_count),
                      dbq_pkg::VALUE_W'(want.entry_count));
          check_field("is_empty", dbq_pkg::VALUE_W'(got.is_empty),
                      dbq_pkg::VALUE_W'(want.is_empty));
          check_field("front_value", got.front_value, want.front_value);
          check_field("back_value", got.back_value, want.back_value);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic queue_req(logic [2:0] action, logic [dbq_pkg::VALUE_W-1:0] operand);
    deque_req_t r;
    r.action  = action;
    r.operand = operand;
    pending_requests.push_back(r);
  endtask

  function automatic logic [dbq_pkg::VALUE_W-1:0] fresh_value();
    logic [dbq_pkg::VALUE_W-1:0] edges[5];
    edges = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1};
    if ($urandom_range(9) == 0) return edges[$urandom_range(4)];
    return $urandom;
  endfunction

  // bursts biased toward filling, draining, or neither
  task automatic queue_random(int n);
    int left, burst, mode, pick, push_w, pop_w;
    logic [2:0] action;
    logic [dbq_pkg::VALUE_W-1:0] value;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(8, 40);
      mode  = $urandom_range(2);
      push_w = (mode == 0) ? 70 : (mode == 1) ? 15 : 36;
      pop_w  = (mode == 0) ? 15 : (mode == 1) ? 70 : 36;
      for (int k = 0; k < burst && left > 0; k++) begin
        pick  = $urandom_range(99);
        value = $urandom;
        if (pick < 3) begin
          action = 3'($urandom_range(5, 7));
        end else if (pick < 3 + push_w) begin
          action = $urandom_range(1) ? dbq_pkg::ACT_PUSH_BACK : dbq_pkg::ACT_PUSH_FRONT;
          value  = fresh_value();
          recent_pushes.push_back(value);
          if (recent_pushes.size() > dbq_pkg::DEPTH) void'(recent_pushes.pop_front());
        end else if (pick < 3 + push_w + pop_w) begin
          action = $urandom_range(1) ? dbq_pkg::ACT_POP_BACK : dbq_pkg::ACT_POP_FRONT;
        end else begin
          action = dbq_pkg::ACT_CONTAINS;
          if (recent_pushes.size() != 0 && $urandom_range(9) < 7)
            value = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
          else
            value = fresh_value();
        end
        queue_req(action, value);
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int send_pct[4];
    int stall_pct[4];
    send_pct  = '{0, 72, 0, 24};
    stall_pct = '{0, 0, 72, 24};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_req(dbq_pkg::ACT_POP_FRONT, 32'h0);
    queue_req(dbq_pkg::ACT_POP_BACK, 32'hffff_ffff);
    queue_req(dbq_pkg::ACT_CONTAINS, 32'h0);
    queue_req(3'd5, 32'h5555_5555);
    queue_req(3'd6, 32'haaaa_aaaa);
    queue_req(3'd7, 32'hffff_ffff);
    queue_req(dbq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
    queue_req(dbq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    queue_req(dbq_pkg::ACT_PUSH_FRONT, 32'hffff_ffff);
    queue_req(dbq_pkg::ACT_PUSH_BACK, 32'h0);
    queue_req(dbq_pkg::ACT_CONTAINS, 32'h8000_0000);
    queue_req(dbq_pkg::ACT_CONTAINS, 32'h0000_3039);
    queue_req(dbq_pkg::ACT_CONTAINS, 32'h7fff_ffff);
    queue_req(dbq_pkg::ACT_POP_FRONT, 32'h0);
    queue_req(dbq_pkg::ACT_POP_BACK, 32'h0);
    queue_req(3'd5, 32'h0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct  = send_pct[p];
      sink_stall_pct = stall_pct[p];
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("%0d requests: %0d pushes, %0d full drops, %0d pops, %0d pops on empty",
             n_requests, n_pushes, n_full, n_pops, n_empty);
    $display("%0d searches (%0d hits), %0d unused action codes, %0d mismatches",
             n_searches, n_hits, n_noops, mismatch_count);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
